[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; empty with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a same-cycle implication on every clock edge outside reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check a next-cycle implication on every clock edge outside reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[hw/rtl/dbc_pkg.sv]
// ---------------------------------------------------------------------------
// dbc_pkg
// Widths, codes, shared types and helpers of the barcode classifier.
// ---------------------------------------------------------------------------
package dbc_pkg;

    // Default sizes for the top-level parameters
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int MAX_BASES_DEF     = 16;

    // Fixed field widths
    localparam int BASE_W   = 3;
    localparam int IN_BASES = 16;
    localparam int SEQ_W    = IN_BASES * BASE_W;
    localparam int LEN_W    = 5;
    localparam int SLOT_W   = 6;
    localparam int CNT_W    = 7;
    localparam int THR_W    = 5;
    localparam int KIND_W   = 3;

    // Operation codes
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_EXACT      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RC_EXACT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FUZZY      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FUZZY_RC   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNASSIGNED = 3'd4;

    // Base codes
    localparam logic [BASE_W-1:0] BASE_A = 3'd0;
    localparam logic [BASE_W-1:0] BASE_C = 3'd1;
    localparam logic [BASE_W-1:0] BASE_G = 3'd2;
    localparam logic [BASE_W-1:0] BASE_T = 3'd3;

    localparam logic [THR_W-1:0] THR_RESET = 5'd1;

    // Control word that travels with every transaction along the chain
    typedef struct packed {
        logic              vld;
        logic              op;
        logic [SLOT_W-1:0] slot;
        logic              ent_vld;
        logic [LEN_W-1:0]  len;
    } t_ctl;

    // Running match state gathered cell by cell
    typedef struct packed {
        logic              ex_any;
        logic [SLOT_W-1:0] ex_slot;
        logic              rx_any;
        logic [SLOT_W-1:0] rx_slot;
        logic              f_any;
        logic              f_multi;
        logic [CNT_W-1:0]  f_cnt;
        logic [SLOT_W-1:0] f_slot;
        logic              r_any;
        logic              r_multi;
        logic [CNT_W-1:0]  r_cnt;
        logic [SLOT_W-1:0] r_slot;
    } t_acc;

    // Swap A/T and C/G, leave other codes as they are
    function automatic logic [BASE_W-1:0] comp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] res;
        if (b <= BASE_T) begin
            res = BASE_T - b;
        end else begin
            res = b;
        end
        return res;
    endfunction

endpackage

[hw/rtl/dbc_channels.sv]
// ---------------------------------------------------------------------------
// dbc_channels
// Valid/ready channel interfaces: item input, result output, configuration.
// ---------------------------------------------------------------------------
interface dbc_in_if import dbc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [SLOT_W-1:0] entry_slot;
    logic              entry_valid;
    logic [SEQ_W-1:0]  sequence_bases;
    logic [LEN_W-1:0]  sequence_length;

    modport source (
        output valid, operation, entry_slot, entry_valid, sequence_bases,
               sequence_length,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_slot, entry_valid, sequence_bases,
               sequence_length,
        output ready
    );
endinterface

interface dbc_out_if import dbc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] match_kind;
    logic [SLOT_W-1:0] matched_slot;
    logic [CNT_W-1:0]  fuzzy_count;
    logic [CNT_W-1:0]  fuzzy_revcomp_count;

    modport source (
        output valid, match_kind, matched_slot, fuzzy_count, fuzzy_revcomp_count,
        input  ready
    );
    modport sink (
        input  valid, match_kind, matched_slot, fuzzy_count, fuzzy_revcomp_count,
        output ready
    );
endinterface

interface dbc_cfg_if import dbc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [THR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[hw/rtl/dna_barcode_classifier_unit.sv]
// ---------------------------------------------------------------------------
// dna_barcode_classifier_unit
// Barcode classifier built as a chain of slot cells with an entry stage and
// a result register.
//
//   port      | role   | transaction
//   ----------+--------+------------------------------------------------
//   i_item    | sink   | load a slot, or classify one index read
//   o_result  | source | kind, slot and fuzzy counts of a classify
//   i_cfg     | sink   | mismatch threshold write, always ready
//
// One transaction enters per cycle while the chain moves; a classify result
// passes the entry register, each cell and the result register; a load gives none.
// The whole chain moves together: while a result waits untaken, every
// stage holds and i_item is not ready.
// Reset clears all slot active flags at once and sets the threshold to 1;
// no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dna_barcode_classifier_unit import dbc_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MAX_BASES     = MAX_BASES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dbc_cfg_if.sink     i_cfg,
    dbc_in_if.sink      i_item,
    dbc_out_if.source   o_result
);

    logic               adv;
    logic [THR_W-1:0]   r_thr;

    t_ctl                               ctl   [TABLE_ENTRIES+1];
    logic [MAX_BASES-1:0][BASE_W-1:0]   bases [TABLE_ENTRIES+1];
    logic [MAX_BASES-1:0][BASE_W-1:0]   rc    [TABLE_ENTRIES+1];
    t_acc                               acc   [TABLE_ENTRIES+1];

    t_acc               last_acc;
    logic               r_out_vld;
    logic [KIND_W-1:0]  n_kind;
    logic [SLOT_W-1:0]  n_slot;
    logic [KIND_W-1:0]  r_kind;
    logic [SLOT_W-1:0]  r_slot;
    logic [CNT_W-1:0]   r_fcnt;
    logic [CNT_W-1:0]   r_rcnt;

    // Threshold register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.data;
        end
    end

    // Move the chain unless a result waits untaken
    assign adv = !r_out_vld || o_result.ready;

    dbc_prep #(
        .MAX_BASES (MAX_BASES)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (i_item),
        .o_ctl   (ctl[0]),
        .o_bases (bases[0]),
        .o_rc    (rc[0])
    );

    assign acc[0] = '0;

    // Row of slot cells
    for (genvar gc = 0; gc < TABLE_ENTRIES; gc++) begin : g_cell
        dbc_cell #(
            .MAX_BASES (MAX_BASES),
            .CELL_IDX  (gc)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_thr   (r_thr),
            .i_ctl   (ctl[gc]),
            .i_bases (bases[gc]),
            .i_rc    (rc[gc]),
            .i_acc   (acc[gc]),
            .o_ctl   (ctl[gc+1]),
            .o_bases (bases[gc+1]),
            .o_rc    (rc[gc+1]),
            .o_acc   (acc[gc+1])
        );
    end

    assign last_acc = acc[TABLE_ENTRIES];

    // Decide by priority: exact, reverse exact, unique fuzzy, unique reverse fuzzy
    always_comb begin
        if (last_acc.ex_any) begin
            n_kind = KIND_EXACT;
            n_slot = last_acc.ex_slot;
        end else if (last_acc.rx_any) begin
            n_kind = KIND_RC_EXACT;
            n_slot = last_acc.rx_slot;
        end else if (last_acc.f_any && !last_acc.f_multi) begin
            n_kind = KIND_FUZZY;
            n_slot = last_acc.f_slot;
        end else if (last_acc.r_any && !last_acc.r_multi) begin
            n_kind = KIND_FUZZY_RC;
            n_slot = last_acc.r_slot;
        end else begin
            n_kind = KIND_UNASSIGNED;
            n_slot = '0;
        end
    end

    // Result register; drop loads at the end of the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= ctl[TABLE_ENTRIES].vld &&
                         (ctl[TABLE_ENTRIES].op == OP_CLASSIFY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_kind <= n_kind;
            r_slot <= n_slot;
            r_fcnt <= last_acc.f_cnt;
            r_rcnt <= last_acc.r_cnt;
        end
    end

    assign o_result.valid               = r_out_vld;
    assign o_result.match_kind          = r_kind;
    assign o_result.matched_slot        = r_slot;
    assign o_result.fuzzy_count         = r_fcnt;
    assign o_result.fuzzy_revcomp_count = r_rcnt;

    // Checks
    `ASSERT_IMP(a_fuzzy_unique, i_clk, i_rst_n,
        o_result.valid && (o_result.match_kind == KIND_FUZZY),
        o_result.fuzzy_count == CNT_W'(1), "fuzzy result without a unique hit")
    `ASSERT_IMP(a_fuzzy_rc_unique, i_clk, i_rst_n,
        o_result.valid && (o_result.match_kind == KIND_FUZZY_RC),
        o_result.fuzzy_revcomp_count == CNT_W'(1), "reverse fuzzy result not unique")
    `ASSERT_IMP(a_stall_blocks_input, i_clk, i_rst_n,
        o_result.valid && !o_result.ready, !i_item.ready, "input taken during stall")
    `ASSERT_NXT(a_load_silent, i_clk, i_rst_n,
        adv && ctl[TABLE_ENTRIES].vld && (ctl[TABLE_ENTRIES].op == OP_LOAD),
        !o_result.valid, "load produced a result")

endmodule

[hw/rtl/dbc_prep.sv]
// ---------------------------------------------------------------------------
// dbc_prep
// Entry stage: clamps the length, masks unused bases, forms the reverse
// complement and registers the transaction for the first cell.
// ---------------------------------------------------------------------------
module dbc_prep import dbc_pkg::*; #(
    parameter int MAX_BASES = MAX_BASES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    dbc_in_if.sink                              i_item,
    output t_ctl                                o_ctl,
    output logic [MAX_BASES-1:0][BASE_W-1:0]    o_bases,
    output logic [MAX_BASES-1:0][BASE_W-1:0]    o_rc
);

    logic [BASE_W-1:0]                  raw [MAX_BASES];
    logic [LEN_W-1:0]                   len_c;
    logic [MAX_BASES-1:0][BASE_W-1:0]   n_bases;
    logic [MAX_BASES-1:0][BASE_W-1:0]   n_rc;
    t_ctl                               n_ctl;
    t_ctl                               r_ctl;
    logic [MAX_BASES-1:0][BASE_W-1:0]   r_bases;
    logic [MAX_BASES-1:0][BASE_W-1:0]   r_rc;

    // Take a transaction whenever the chain moves
    assign i_item.ready = i_adv;

    // Pick the raw bases; positions past the input field read as zero
    for (genvar gi = 0; gi < MAX_BASES; gi++) begin : g_raw
        if (gi < IN_BASES) begin : g_in
            assign raw[gi] = i_item.sequence_bases[BASE_W*gi +: BASE_W];
        end else begin : g_pad
            assign raw[gi] = '0;
        end
    end

    // Saturate the length to the table's base count
    assign len_c = (i_item.sequence_length > LEN_W'(MAX_BASES)) ?
                   LEN_W'(MAX_BASES) : i_item.sequence_length;

    // Mask the read and build its reverse complement over the used length
    always_comb begin
        for (int i = 0; i < MAX_BASES; i++) begin
            n_bases[i] = (LEN_W'(i) < len_c) ? raw[i] : '0;
        end
        for (int i = 0; i < MAX_BASES; i++) begin
            n_rc[i] = '0;
            for (int j = 0; j < MAX_BASES; j++) begin
                if ({1'b0, len_c} == (LEN_W+1)'(i + j + 1)) begin
                    n_rc[i] = comp_base(n_bases[j]);
                end
            end
        end
    end

    always_comb begin
        n_ctl.vld     = i_item.valid;
        n_ctl.op      = i_item.operation;
        n_ctl.slot    = i_item.entry_slot;
        n_ctl.ent_vld = i_item.entry_valid;
        n_ctl.len     = len_c;
    end

    // Hold control under stall, clear on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_bases <= n_bases;
            r_rc    <= n_rc;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_bases = r_bases;
    assign o_rc    = r_rc;

endmodule

[hw/rtl/dbc_cell.sv]
// ---------------------------------------------------------------------------
// dbc_cell
// One table slot: holds a barcode, takes loads addressed to it, scores each
// passing read and its reverse complement, and forwards the transaction.
// ---------------------------------------------------------------------------
module dbc_cell import dbc_pkg::*; #(
    parameter int MAX_BASES = MAX_BASES_DEF,
    parameter int CELL_IDX  = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic [THR_W-1:0]                    i_thr,
    input  t_ctl                                i_ctl,
    input  logic [MAX_BASES-1:0][BASE_W-1:0]    i_bases,
    input  logic [MAX_BASES-1:0][BASE_W-1:0]    i_rc,
    input  t_acc                                i_acc,
    output t_ctl                                o_ctl,
    output logic [MAX_BASES-1:0][BASE_W-1:0]    o_bases,
    output logic [MAX_BASES-1:0][BASE_W-1:0]    o_rc,
    output t_acc                                o_acc
);

    localparam int                DIST_W   = $clog2(MAX_BASES + 1);
    localparam logic              IN_RANGE = (CELL_IDX < (1 << SLOT_W));
    localparam logic [SLOT_W-1:0] MY_SLOT  = SLOT_W'(CELL_IDX);

    logic [MAX_BASES-1:0][BASE_W-1:0]   r_entry;
    logic [LEN_W-1:0]                   r_len;
    logic                               r_active;
    t_ctl                               r_ctl;
    logic [MAX_BASES-1:0][BASE_W-1:0]   r_bases;
    logic [MAX_BASES-1:0][BASE_W-1:0]   r_rc;
    t_acc                               r_acc;
    t_acc                               n_acc;

    logic                   wr;
    logic                   cmp;
    logic [MAX_BASES-1:0]   neq_f;
    logic [MAX_BASES-1:0]   neq_r;
    logic [DIST_W-1:0]      df;
    logic [DIST_W-1:0]      dr;
    logic                   f_hit;
    logic                   r_hit;

    // Load addressed to this slot
    assign wr = i_adv && i_ctl.vld && (i_ctl.op == OP_LOAD) && IN_RANGE &&
                (i_ctl.slot == MY_SLOT);

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_entry <= i_bases;
            r_len   <= i_ctl.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (wr) begin
            r_active <= i_ctl.ent_vld;
        end
    end

    // Hamming distances of the read and its reverse complement
    always_comb begin
        for (int i = 0; i < MAX_BASES; i++) begin
            neq_f[i] = (i_bases[i] != r_entry[i]);
            neq_r[i] = (i_rc[i] != r_entry[i]);
        end
    end

    assign df    = DIST_W'($countones(neq_f));
    assign dr    = DIST_W'($countones(neq_r));
    assign cmp   = r_active && (r_len == i_ctl.len) && (i_ctl.op == OP_CLASSIFY);
    assign f_hit = cmp && (THR_W'(df) <= i_thr);
    assign r_hit = cmp && (THR_W'(dr) <= i_thr);

    // Fold this slot into the running match state; lowest slot wins
    always_comb begin
        n_acc = i_acc;
        if (cmp && (df == '0) && !i_acc.ex_any) begin
            n_acc.ex_any  = 1'b1;
            n_acc.ex_slot = MY_SLOT;
        end
        if (cmp && (dr == '0) && !i_acc.rx_any) begin
            n_acc.rx_any  = 1'b1;
            n_acc.rx_slot = MY_SLOT;
        end
        if (f_hit) begin
            if (!i_acc.f_any) begin
                n_acc.f_any  = 1'b1;
                n_acc.f_slot = MY_SLOT;
            end else begin
                n_acc.f_multi = 1'b1;
            end
            n_acc.f_cnt = i_acc.f_cnt + CNT_W'(1);
        end
        if (r_hit) begin
            if (!i_acc.r_any) begin
                n_acc.r_any  = 1'b1;
                n_acc.r_slot = MY_SLOT;
            end else begin
                n_acc.r_multi = 1'b1;
            end
            n_acc.r_cnt = i_acc.r_cnt + CNT_W'(1);
        end
    end

    // Advance to the neighbour
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_bases <= i_bases;
            r_rc    <= i_rc;
            r_acc   <= n_acc;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_bases = r_bases;
    assign o_rc    = r_rc;
    assign o_acc   = r_acc;

endmodule
